@@ design/i2cram_pkg.sv @@
// i2cram_pkg: shared types and constants of the i2c register access master
// used by the register block, the bus engine and the top level

package i2cram_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register indexes (byte address bit 2)
  localparam logic REG_DEVICE_ADDRESS    = 1'b0;
  localparam logic REG_READ_BURST_LENGTH = 1'b1;

  localparam logic [6:0] DeviceAddressReset   = 7'd76;
  localparam logic [1:0] ReadBurstLengthReset = 2'd3;

  typedef struct packed {
    logic [6:0] device_address;
    logic [1:0] read_burst_length;
  } cfg_t;

  typedef struct packed {
    logic       command_valid;
    logic       mode;
    logic [7:0] register_index;
    logic [7:0] write_value;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       clock_line;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] read_byte0;
    logic [7:0] read_byte1;
    logic [7:0] read_byte2;
  } res_t;

endpackage

@@ design/i2cram_cmd_if.sv @@
// i2cram_cmd_if: request channel carrying one bus timing slot per request
// stands alone, no package needed

interface i2cram_cmd_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic       mode;
  logic [7:0] register_index;
  logic [7:0] write_value;
  logic       sda_sample;

  modport source (output valid, command_valid, mode, register_index, write_value, sda_sample,
                  input ready);
  modport sink   (input valid, command_valid, mode, register_index, write_value, sda_sample,
                  output ready);
endinterface

@@ design/i2cram_res_if.sv @@
// i2cram_res_if: result channel carrying the line levels and status of one slot
// stands alone, no package needed

interface i2cram_res_if;
  logic       valid;
  logic       ready;
  logic       clock_line;
  logic       data_out;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic       nack_error;
  logic [7:0] read_byte0;
  logic [7:0] read_byte1;
  logic [7:0] read_byte2;

  modport source (output valid, clock_line, data_out, data_drive, busy_res, done_res,
                  nack_error, read_byte0, read_byte1, read_byte2,
                  input ready);
  modport sink   (input valid, clock_line, data_out, data_drive, busy_res, done_res,
                  nack_error, read_byte0, read_byte1, read_byte2,
                  output ready);
endinterface

@@ design/i2cram_regs.sv @@
// i2cram_regs: apb configuration registers (device address, read burst length)
// depends on i2cram_pkg

module i2cram_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [i2cram_pkg::AddrW-1:0] paddr,
  input  logic [i2cram_pkg::DataW-1:0] pwdata,
  output logic [i2cram_pkg::DataW-1:0] prdata,
  output logic                        pready,
  output i2cram_pkg::cfg_t            cfg_o
);

  i2cram_pkg::cfg_t cfg_q, cfg_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        i2cram_pkg::REG_DEVICE_ADDRESS:    cfg_d.device_address    = pwdata[6:0];
        i2cram_pkg::REG_READ_BURST_LENGTH: cfg_d.read_burst_length = pwdata[1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= i2cram_pkg::DeviceAddressReset;
      cfg_q.read_burst_length <= i2cram_pkg::ReadBurstLengthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      i2cram_pkg::REG_DEVICE_ADDRESS:    prdata = {25'd0, cfg_q.device_address};
      i2cram_pkg::REG_READ_BURST_LENGTH: prdata = {30'd0, cfg_q.read_burst_length};
      default:                           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/i2cram_engine.sv @@
// i2cram_engine: slot sequencer that drives scl/sda for register writes and burst reads
// depends on i2cram_pkg

module i2cram_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cram_pkg::cmd_t  cmd_i,
  input  i2cram_pkg::cfg_t  cfg_i,
  output i2cram_pkg::res_t  res_o
);

  typedef enum logic [18:0] {
    PH_IDLE  = 19'h00001,
    PH_ST0   = 19'h00002,
    PH_ST1   = 19'h00004,
    PH_ST2   = 19'h00008,
    PH_WPRE  = 19'h00010,
    PH_WLOW  = 19'h00020,
    PH_WSET  = 19'h00040,
    PH_WHIGH = 19'h00080,
    PH_AK0   = 19'h00100,
    PH_AK1   = 19'h00200,
    PH_AK2   = 19'h00400,
    PH_RPRE  = 19'h00800,
    PH_RLOW  = 19'h01000,
    PH_RHIGH = 19'h02000,
    PH_MA0   = 19'h04000,
    PH_MA1   = 19'h08000,
    PH_SP0   = 19'h10000,
    PH_SP1   = 19'h20000,
    PH_SP2   = 19'h40000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [16:0] held_q, held_d;
  logic [23:0] rx_q, rx_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        drv_q, drv_d;
  logic [1:0]  burst_len;
  logic [2:0]  next_cnt;

  // byte sent at a stage: address, register, then data or read address
  function automatic logic [7:0] stage_byte(input logic [1:0] stage, input logic [16:0] held,
                                            input logic [6:0] addr);
    logic [7:0] b;
    begin
      case (stage)
        2'd0:    b = {addr, 1'b0};
        2'd1:    b = held[15:8];
        default: b = held[16] ? {addr, 1'b1} : held[7:0];
      endcase
      return b;
    end
  endfunction

  assign burst_len = (cfg_i.read_burst_length == 2'd0) ? 2'd1 : cfg_i.read_burst_length;

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    byte_cnt_d = byte_cnt_q;
    held_d     = held_q;
    rx_d       = rx_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drv_d      = drv_q;
    next_cnt   = {1'b0, byte_cnt_q} + 3'd1;
    res_o      = '0;

    if (phase_q == PH_IDLE && cmd_i.command_valid) begin
      held_d     = {cmd_i.mode, cmd_i.register_index, cmd_i.write_value};
      byte_cnt_d = 2'd0;
      bit_cnt_d  = 4'd0;
      if (cmd_i.mode) begin
        rx_d = '0;
      end
      phase_d = PH_ST0;
    end
    res_o.busy_res = (phase_d != PH_IDLE);
    next_cnt       = {1'b0, byte_cnt_d} + 3'd1;

    case (phase_d)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_ST0: begin
        drv_d = 1'b1; sda_d = 1'b1; phase_d = PH_ST1;
      end
      PH_ST1: begin
        scl_d = 1'b1; phase_d = PH_ST2;
      end
      PH_ST2: begin
        sda_d   = 1'b0;
        shift_d = stage_byte(byte_cnt_d, held_d, cfg_i.device_address);
        phase_d = PH_WPRE;
      end
      PH_WPRE: begin
        scl_d = 1'b0; bit_cnt_d = 4'd0; phase_d = PH_WLOW;
      end
      PH_WLOW: begin
        scl_d = 1'b0; phase_d = PH_WSET;
      end
      PH_WSET: begin
        sda_d   = shift_d[7];
        shift_d = {shift_d[6:0], 1'b0};
        phase_d = PH_WHIGH;
      end
      PH_WHIGH: begin
        scl_d     = 1'b1;
        bit_cnt_d = bit_cnt_d + 4'd1;
        phase_d   = (bit_cnt_d >= 4'd8) ? PH_AK0 : PH_WLOW;
      end
      PH_AK0: begin
        scl_d = 1'b0; drv_d = 1'b0; sda_d = 1'b0; phase_d = PH_AK1;
      end
      PH_AK1: begin
        scl_d = 1'b1; shift_d = {7'd0, cmd_i.sda_sample}; phase_d = PH_AK2;
      end
      PH_AK2: begin
        scl_d = 1'b0;
        if (shift_d[0]) begin
          res_o.done_res   = 1'b1;
          res_o.nack_error = 1'b1;
          phase_d          = PH_IDLE;
        end else if (byte_cnt_d == 2'd0) begin
          byte_cnt_d = 2'd1;
          shift_d    = stage_byte(2'd1, held_d, cfg_i.device_address);
          phase_d    = PH_WPRE;
        end else if (byte_cnt_d == 2'd1) begin
          byte_cnt_d = 2'd2;
          if (!held_d[16]) begin
            shift_d = stage_byte(2'd2, held_d, cfg_i.device_address);
            phase_d = PH_WPRE;
          end else begin
            phase_d = PH_ST0;
          end
        end else if (!held_d[16]) begin
          phase_d = PH_SP0;
        end else begin
          byte_cnt_d = 2'd0;
          phase_d    = PH_RPRE;
        end
      end
      PH_RPRE: begin
        scl_d = 1'b0; bit_cnt_d = 4'd0; shift_d = 8'd0; phase_d = PH_RLOW;
      end
      PH_RLOW: begin
        scl_d = 1'b0; phase_d = PH_RHIGH;
      end
      PH_RHIGH: begin
        scl_d     = 1'b1;
        shift_d   = {shift_d[6:0], cmd_i.sda_sample};
        bit_cnt_d = bit_cnt_d + 4'd1;
        if (bit_cnt_d >= 4'd8) begin
          case (byte_cnt_d)
            2'd0:    rx_d[7:0]   = shift_d;
            2'd1:    rx_d[15:8]  = shift_d;
            2'd2:    rx_d[23:16] = shift_d;
            default: rx_d        = rx_q;
          endcase
          phase_d = PH_MA0;
        end else begin
          phase_d = PH_RLOW;
        end
      end
      PH_MA0: begin
        scl_d   = 1'b0;
        drv_d   = 1'b1;
        sda_d   = (next_cnt < {1'b0, burst_len}) ? 1'b0 : 1'b1;
        phase_d = PH_MA1;
      end
      PH_MA1: begin
        scl_d = 1'b1;
        if (!sda_d) begin
          byte_cnt_d = next_cnt[1:0];
          phase_d    = PH_RPRE;
        end else begin
          phase_d = PH_SP0;
        end
      end
      PH_SP0: begin
        drv_d = 1'b1; sda_d = 1'b0; phase_d = PH_SP1;
      end
      PH_SP1: begin
        scl_d = 1'b1; phase_d = PH_SP2;
      end
      PH_SP2: begin
        sda_d = 1'b1; res_o.done_res = 1'b1; phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    res_o.clock_line = scl_d;
    res_o.data_drive = drv_d;
    res_o.data_out   = drv_d & sda_d;
    res_o.read_byte0 = rx_d[7:0];
    res_o.read_byte1 = rx_d[15:8];
    res_o.read_byte2 = rx_d[23:16];

    // line changes that take effect after the slot is shown
    if (phase_q == PH_WPRE) begin
      drv_d = 1'b1; sda_d = 1'b1;
    end
    if (phase_q == PH_RPRE) begin
      drv_d = 1'b0; sda_d = 1'b0;
    end
    if (phase_q == PH_MA1) begin
      scl_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 4'd0;
      shift_q    <= 8'd0;
      byte_cnt_q <= 2'd0;
      held_q     <= 17'd0;
      rx_q       <= 24'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      drv_q      <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      byte_cnt_q <= byte_cnt_d;
      held_q     <= held_d;
      rx_q       <= rx_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      drv_q      <= drv_d;
    end
  end

endmodule

@@ design/i2c_register_access_master.sv @@
// i2c_register_access_master: top level, apb registers, slot engine and result register
// depends on i2cram_pkg, i2cram_cmd_if, i2cram_res_if, i2cram_regs, i2cram_engine
//
//   channel   dir   handshake             payload
//   cmd_i     in    valid/ready           one bus slot: command fields and sda sample
//   res_o     out   valid/ready           scl/sda levels, status, read bytes
//   apb       in    psel/penable/pwrite   device_address (0x0), read_burst_length (0x4)
//
// one request per clock while res_o is not holding back a result; its result is registered and shows the next cycle
// the engine state steps once per accepted request, in a single pass of logic
// a held result still lets the next request in when res_o.ready is high
// reset returns to idle with scl high and sda driven high, registers at defaults

module i2c_register_access_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  i2cram_cmd_if.sink                   cmd_i,
  i2cram_res_if.source                 res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cram_pkg::AddrW-1:0] paddr,
  input  logic [i2cram_pkg::DataW-1:0] pwdata,
  output logic [i2cram_pkg::DataW-1:0] prdata,
  output logic                         pready
);

  i2cram_pkg::cfg_t cfg;
  i2cram_pkg::cmd_t cmd;
  i2cram_pkg::res_t res_d, res_q;
  logic             out_valid_q;
  logic             step;

  i2cram_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign cmd.command_valid  = cmd_i.command_valid;
  assign cmd.mode           = cmd_i.mode;
  assign cmd.register_index = cmd_i.register_index;
  assign cmd.write_value    = cmd_i.write_value;
  assign cmd.sda_sample     = cmd_i.sda_sample;

  assign cmd_i.ready = ~out_valid_q | res_o.ready;
  assign step        = cmd_i.valid & cmd_i.ready;

  i2cram_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.clock_line = res_q.clock_line;
  assign res_o.data_out   = res_q.data_out;
  assign res_o.data_drive = res_q.data_drive;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.done_res   = res_q.done_res;
  assign res_o.nack_error = res_q.nack_error;
  assign res_o.read_byte0 = res_q.read_byte0;
  assign res_o.read_byte1 = res_q.read_byte1;
  assign res_o.read_byte2 = res_q.read_byte2;

endmodule
